// ----- rtl/core/vpbm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package vpbm_pkg;

  localparam int BONES     = 20;
  localparam int BONE_W    = 5;
  localparam int MAX_MAP   = 64;
  localparam int MAX_DEPTH = 64;
  localparam int FRAC_BITS = 16;
  localparam int GEO_WORDS = 10;
  localparam int PIX_W     = 13;
  localparam int STEP_W    = 3;

  localparam logic [1:0] KIND_GEO = 2'd0;
  localparam logic [1:0] KIND_BOX = 2'd1;
  localparam logic [1:0] KIND_VOX = 2'd2;

  localparam logic [2:0] REG_FOCAL_X  = 3'd0;
  localparam logic [2:0] REG_FOCAL_Y  = 3'd1;
  localparam logic [2:0] REG_CENTER_U = 3'd2;
  localparam logic [2:0] REG_CENTER_V = 3'd3;
  localparam logic [2:0] REG_IMG_SIZE = 3'd4;
  localparam logic [2:0] REG_MAP_SIZE = 3'd5;
  localparam logic [2:0] REG_DEPTH    = 3'd6;
  localparam logic [2:0] REG_SHARED   = 3'd7;

  // projection steps, run in this order through the shared divider
  localparam logic [STEP_W-1:0] STEP_X  = 3'd0;
  localparam logic [STEP_W-1:0] STEP_Y  = 3'd1;
  localparam logic [STEP_W-1:0] STEP_Z  = 3'd2;
  localparam logic [STEP_W-1:0] STEP_U  = 3'd3;
  localparam logic [STEP_W-1:0] STEP_V  = 3'd4;
  localparam logic [STEP_W-1:0] STEP_PC = 3'd5;
  localparam logic [STEP_W-1:0] STEP_PR = 3'd6;

  typedef struct packed {
    logic              load_in;
    logic              prep;
    logic              div_start;
    logic              fin;
    logic              emit;
    logic [STEP_W-1:0] step;
    logic [BONE_W-1:0] bone;
    logic              bone_last;
  } dp_cmd_t;

  typedef struct packed {
    logic              div_done;
    logic              vox_go;
    logic              out_free;
    logic [BONE_W-1:0] bone_first;
    logic [BONE_W-1:0] bone_end;
  } dp_stat_t;

endpackage
`default_nettype wire

// ----- rtl/core/voxel_project_bone_patch_mask.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Voxel projection into bone patch masks.
// in_* channel: tuser = kind (geometry load, patch box load, voxel). Loads
//   give no result. A voxel maps its position into the cube, projects it
//   through the camera and turns it into a clamped pixel.
// out_* channel: one item per bone (all bones in order when REG_SHARED is set,
//   else bone_sel only, none if out of range), tlast on the voxel's last item.
// cfg_* channel: register index and 32-bit data, always ready.
// Flow: seven quotients go one at a time through a single bit-serial
//   divider, then each bone's result follows the registered read of the
//   patch box RAMs. The next item is taken once the last result of the
//   voxel sits in the output register.
// Reset sets the registers to their defaults and empties the output
//   register; geometry and patch words hold nothing until loaded.
// A stalled receiver holds the output register and the sequencer waits.
module voxel_project_bone_patch_mask (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // index[6:0], value[38:7], depth_idx[44:39], row_idx[50:45],
  // col_idx[56:51], bone_sel[61:57], zero[63:62]
  input  wire logic [63:0] in_tdata,
  // kind[1:0]
  input  wire logic [1:0]  in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // out_bone[4:0], out_depth[10:5], out_row[16:11], out_col[22:17],
  // inside_res[23], out_value[55:24]
  output logic [55:0]      out_tdata,
  output logic             out_tlast,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_addr,
  input  wire logic [31:0] cfg_data
);
  import vpbm_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_ready = 1'b1;

  vpbm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  vpbm_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data)
  );

endmodule
`default_nettype wire

// ----- rtl/core/vpbm_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
module vpbm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 20,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- rtl/core/vpbm_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
module vpbm_div (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic signed [63:0] num,
  input  wire logic signed [33:0] den,
  output logic                    done,
  output logic signed [31:0]      quo
);

  logic [63:0] nq_r, nq_nxt;
  logic [33:0] rem_r, rem_nxt;
  logic [33:0] dmag_r, dmag_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic        neg_r, neg_nxt;
  logic        nneg_r, nneg_nxt;
  logic        nzero_r, nzero_nxt;
  logic        dzero_r, dzero_nxt;
  logic [34:0] rem_sh;

  always_comb begin
    nq_nxt    = nq_r;
    rem_nxt   = rem_r;
    dmag_nxt  = dmag_r;
    cnt_nxt   = cnt_r;
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    neg_nxt   = neg_r;
    nneg_nxt  = nneg_r;
    nzero_nxt = nzero_r;
    dzero_nxt = dzero_r;
    rem_sh    = {rem_r, nq_r[63]};
    if (start) begin
      nq_nxt    = num[63] ? 64'(-num) : 64'(num);
      dmag_nxt  = den[33] ? 34'(-den) : 34'(den);
      rem_nxt   = '0;
      cnt_nxt   = 7'd64;
      busy_nxt  = 1'b1;
      neg_nxt   = num[63] ^ den[33];
      nneg_nxt  = num[63];
      nzero_nxt = (num == '0);
      dzero_nxt = (den == '0);
    end else if (busy_r) begin
      if (rem_sh >= {1'b0, dmag_r}) begin
        rem_nxt = 34'(rem_sh - {1'b0, dmag_r});
        nq_nxt  = {nq_r[62:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[33:0];
        nq_nxt  = {nq_r[62:0], 1'b0};
      end
      cnt_nxt = cnt_r - 7'd1;
      if (cnt_r == 7'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    nq_r    <= nq_nxt;
    rem_r   <= rem_nxt;
    dmag_r  <= dmag_nxt;
    neg_r   <= neg_nxt;
    nneg_r  <= nneg_nxt;
    nzero_r <= nzero_nxt;
    dzero_r <= dzero_nxt;
  end

  assign done = done_r;

  // truncating quotient, saturated to 32 bits
  always_comb begin
    if (dzero_r) begin
      if (nzero_r)     quo = '0;
      else if (nneg_r) quo = 32'sh8000_0000;
      else             quo = 32'sh7FFF_FFFF;
    end else if (neg_r) begin
      if (nq_r > 64'h8000_0000) quo = 32'sh8000_0000;
      else                      quo = 32'(-nq_r);
    end else begin
      if (nq_r > 64'h7FFF_FFFF) quo = 32'sh7FFF_FFFF;
      else                      quo = nq_r[31:0];
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/vpbm_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none
module vpbm_dp (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire vpbm_pkg::dp_cmd_t cmd,
  output vpbm_pkg::dp_stat_t     stat,
  input  wire logic [63:0]       in_tdata,
  input  wire logic [1:0]        in_tuser,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [55:0]            out_tdata,
  output logic                   out_tlast,
  input  wire logic              cfg_valid,
  input  wire logic [2:0]        cfg_addr,
  input  wire logic [31:0]       cfg_data
);
  import vpbm_pkg::*;

  function automatic logic signed [31:0] sat32(input logic signed [32:0] s);
    if (s[32] != s[31]) sat32 = s[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    else                sat32 = s[31:0];
  endfunction

  // config
  logic signed [31:0] fx_r, fy_r, cu_r, cv_r;
  logic [12:0]        img_r;
  logic [6:0]         map_r, dep_r;
  logic               shared_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fx_r <= '0; fy_r <= '0; cu_r <= '0; cv_r <= '0;
      img_r <= 13'd128; map_r <= 7'd32; dep_r <= 7'd32; shared_r <= 1'b1;
    end else if (cfg_valid) begin
      case (cfg_addr)
        REG_FOCAL_X:  fx_r <= cfg_data;
        REG_FOCAL_Y:  fy_r <= cfg_data;
        REG_CENTER_U: cu_r <= cfg_data;
        REG_CENTER_V: cv_r <= cfg_data;
        REG_IMG_SIZE: img_r <= cfg_data[12:0];
        REG_MAP_SIZE: map_r <= cfg_data[6:0];
        REG_DEPTH:    dep_r <= cfg_data[6:0];
        REG_SHARED:   shared_r <= cfg_data[0];
        default:      ;
      endcase
    end
  end

  // input fields
  logic [6:0]  in_idx;
  logic [31:0] in_val;
  logic [4:0]  in_sel;
  assign in_idx = in_tdata[6:0];
  assign in_val = in_tdata[38:7];
  assign in_sel = in_tdata[61:57];

  logic [31:0] val_r;
  logic [5:0]  vd_r, vr_r, vc_r;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      val_r <= in_val;
      vd_r  <= in_tdata[44:39];
      vr_r  <= in_tdata[50:45];
      vc_r  <= in_tdata[56:51];
    end
  end

  logic signed [31:0] geo_r [GEO_WORDS];
  always_ff @(posedge clk) begin
    if (cmd.load_in && in_tuser == KIND_GEO && in_idx < 7'(GEO_WORDS)) begin
      geo_r[in_idx[3:0]] <= in_val;
    end
  end

  // patch boxes: one RAM per box coordinate word, addressed by bone
  logic        box_we;
  logic [31:0] box_q [4];
  assign box_we = cmd.load_in && in_tuser == KIND_BOX && in_idx < 7'(BONES * 4);

  for (genvar k = 0; k < 4; k++) begin : g_box
    vpbm_ram #(.WIDTH(32), .DEPTH(BONES)) u_ram (
      .clk   (clk),
      .we    (box_we && in_idx[1:0] == 2'(k)),
      .waddr (in_idx[6:2]),
      .wdata (in_val),
      .raddr (cmd.bone),
      .rdata (box_q[k])
    );
  end

  // operand selection for the shared multiply and divide
  logic [6:0]         ms, dd;
  logic signed [33:0] ma, mb, den_sel;
  logic signed [31:0] add_sel;
  logic signed [67:0] prod;
  logic signed [63:0] prod_r;
  logic signed [33:0] den_r;
  logic signed [31:0] add_r;
  logic signed [31:0] gx_r, gy_r, gz_r, gu_r, gv_r;
  logic [PIX_W-1:0]   pc_r, pr_r;

  assign ms = (map_r > 7'(MAX_MAP)) ? 7'(MAX_MAP) : map_r;
  assign dd = (dep_r > 7'(MAX_DEPTH)) ? 7'(MAX_DEPTH) : dep_r;

  function automatic logic signed [33:0] dif(input logic signed [31:0] a,
                                             input logic signed [31:0] b);
    dif = 34'(signed'({a[31], a}) - signed'({b[31], b}));
  endfunction

  always_comb begin
    ma = '0; mb = '0; den_sel = '0; add_sel = '0;
    case (cmd.step)
      STEP_X: begin
        ma = signed'({28'b0, vc_r}); mb = dif(geo_r[5], geo_r[4]);
        den_sel = signed'({27'b0, ms}); add_sel = geo_r[4];
      end
      STEP_Y: begin
        ma = signed'({28'b0, vr_r}); mb = dif(geo_r[7], geo_r[6]);
        den_sel = signed'({27'b0, ms}); add_sel = geo_r[6];
      end
      STEP_Z: begin
        ma = signed'({28'b0, vd_r}); mb = dif(geo_r[9], geo_r[8]);
        den_sel = signed'({27'b0, dd}); add_sel = geo_r[8];
      end
      STEP_U: begin
        ma = 34'(fx_r); mb = 34'(gx_r); den_sel = 34'(gz_r); add_sel = cu_r;
      end
      STEP_V: begin
        ma = 34'(fy_r); mb = 34'(gy_r); den_sel = 34'(gz_r); add_sel = cv_r;
      end
      STEP_PC: begin
        ma = dif(gu_r, geo_r[0]); mb = signed'({21'b0, img_r});
        den_sel = dif(geo_r[2], geo_r[0]);
      end
      STEP_PR: begin
        ma = dif(gv_r, geo_r[1]); mb = signed'({21'b0, img_r});
        den_sel = dif(geo_r[3], geo_r[1]);
      end
      default: ;
    endcase
  end

  assign prod = ma * mb;

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      prod_r <= prod[63:0];
      den_r  <= den_sel;
      add_r  <= add_sel;
    end
  end

  logic               div_done;
  logic signed [31:0] quo;

  vpbm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (prod_r),
    .den   (den_r),
    .done  (div_done),
    .quo   (quo)
  );

  logic signed [31:0] sum;
  logic [PIX_W-1:0]   top, pix;
  assign sum = sat32(33'(signed'({quo[31], quo}) + signed'({add_r[31], add_r})));
  assign top = (img_r == '0) ? '0 : img_r - 13'd1;

  always_comb begin
    if (quo[31])                           pix = '0;
    else if (quo > signed'({19'b0, top}))  pix = top;
    else                                   pix = quo[PIX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      case (cmd.step)
        STEP_X:  gx_r <= sum;
        STEP_Y:  gy_r <= sum;
        STEP_Z:  gz_r <= sum;
        STEP_U:  gu_r <= sum;
        STEP_V:  gv_r <= sum;
        STEP_PC: pc_r <= pix;
        STEP_PR: pr_r <= pix;
        default: ;
      endcase
    end
  end

  // pixel against this bone's box, box words at FRAC_BITS fraction
  localparam int PAD = 33 - PIX_W - FRAC_BITS;
  logic signed [32:0] cx, ry, bx1, by1, bx2, by2;
  logic               in_patch;
  assign cx  = signed'({{PAD{1'b0}}, pc_r, {FRAC_BITS{1'b0}}});
  assign ry  = signed'({{PAD{1'b0}}, pr_r, {FRAC_BITS{1'b0}}});
  assign bx1 = signed'({box_q[0][31], box_q[0]});
  assign by1 = signed'({box_q[1][31], box_q[1]});
  assign bx2 = signed'({box_q[2][31], box_q[2]});
  assign by2 = signed'({box_q[3][31], box_q[3]});
  assign in_patch = (cx >= bx1) && (cx < bx2) && (ry >= by1) && (ry < by2);

  // output register
  logic        ov_r, ov_nxt;
  logic [55:0] od_r;
  logic        ol_r;

  always_comb begin
    ov_nxt = ov_r;
    if (cmd.emit)       ov_nxt = 1'b1;
    else if (out_tready) ov_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else        ov_r <= ov_nxt;
    if (cmd.emit) begin
      od_r <= {in_patch ? val_r : 32'b0, in_patch, vc_r, vr_r, vd_r, cmd.bone};
      ol_r <= cmd.bone_last;
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;
  assign out_tlast  = ol_r;

  assign stat.div_done   = div_done;
  assign stat.vox_go     = (in_tuser == KIND_VOX) && (shared_r || in_sel < 5'(BONES));
  assign stat.out_free   = !ov_r || out_tready;
  assign stat.bone_first = shared_r ? '0 : in_sel;
  assign stat.bone_end   = shared_r ? BONE_W'(BONES - 1) : in_sel;

endmodule
`default_nettype wire

// ----- rtl/core/vpbm_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
module vpbm_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire vpbm_pkg::dp_stat_t stat,
  output vpbm_pkg::dp_cmd_t      cmd
);
  import vpbm_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_PREP = 7'b0000010,
    S_LOAD = 7'b0000100,
    S_DIV  = 7'b0001000,
    S_FIN  = 7'b0010000,
    S_RD   = 7'b0100000,
    S_EMIT = 7'b1000000
  } state_t;

  state_t            state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [BONE_W-1:0] bone_r, bone_nxt, end_r, end_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    bone_nxt      = bone_r;
    end_nxt       = end_r;
    cmd           = '0;
    cmd.step      = step_r;
    cmd.bone      = bone_r;
    cmd.bone_last = (bone_r == end_r);
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load_in = 1'b1;
          if (stat.vox_go) begin
            step_nxt  = STEP_X;
            bone_nxt  = stat.bone_first;
            end_nxt   = stat.bone_end;
            state_nxt = S_PREP;
          end
        end
      end
      S_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DIV;
      end
      S_DIV: begin
        if (stat.div_done) state_nxt = S_FIN;
      end
      S_FIN: begin
        cmd.fin = 1'b1;
        if (step_r == STEP_PR) begin
          state_nxt = S_RD;
        end else begin
          step_nxt  = step_r + STEP_W'(1);
          state_nxt = S_PREP;
        end
      end
      S_RD: state_nxt = S_EMIT;
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          if (bone_r == end_r) begin
            state_nxt = S_IDLE;
          end else begin
            bone_nxt  = bone_r + BONE_W'(1);
            state_nxt = S_RD;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
      bone_r  <= '0;
      end_r   <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      bone_r  <= bone_nxt;
      end_r   <= end_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;
  import vpbm_pkg::*;

  localparam logic [31:0] Q        = 32'h0001_0000;
  localparam int          WD_LIMIT = 20000;
  localparam int          SETTLE   = 600;
  localparam int          PER_PHASE = 10;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [55:0] out_tdata;
  logic        out_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_addr = '0;
  logic [31:0] cfg_data = '0;

  always #5 clk = ~clk;

  voxel_project_bone_patch_mask dut (.*);

  typedef struct packed {
    logic [4:0]  bone;
    logic [5:0]  dep;
    logic [5:0]  row;
    logic [5:0]  col;
    logic        in_patch;
    logic [31:0] value;
    logic        last;
  } mask_res_t;

  typedef struct {
    logic [1:0]  kind;
    logic [6:0]  idx;
    logic [31:0] val;
    logic [5:0]  dep, row, col;
    logic [4:0]  sel;
    int          n_res;  // -1: left to the predictor alone
  } dir_row_t;

  mask_res_t mask_q[$];
  dir_row_t  dir_tab[$];

  // shadow of the block
  logic signed [31:0] fx_r, fy_r, cu_r, cv_r;
  logic [12:0]        img_r;
  logic [6:0]         map_r, dep_r;
  logic               shared_r;
  logic signed [31:0] geo_w[GEO_WORDS];
  logic signed [31:0] box_w[BONES*4];

  int errors = 0, n_voxels = 0, n_results = 0, n_items = 0;
  int idle_cnt = 0;
  bit hold_req = 1'b0;

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint div_sat(longint n, longint d);
    if (d == 0) return (n > 0) ? 64'sd2147483647 : (n < 0) ? -64'sd2147483648 : 0;
    return sat32(n / d);
  endfunction

  function automatic longint cube_pt(longint pos, longint lb, longint ub, longint n);
    return sat32(lb + div_sat(pos * (ub - lb), n));
  endfunction

  function automatic longint pixel_of(longint g, longint lo, longint hi);
    longint t, top;
    t = div_sat((g - lo) * longint'(img_r), hi - lo);
    top = (img_r == 0) ? 0 : longint'(img_r) - 1;
    if (t < 0) t = 0;
    if (t > top) t = top;
    return t;
  endfunction

  // applies one accepted item to the shadow, queues its masks, returns their count
  function automatic int project_and_mask(logic [1:0] kind, logic [6:0] idx,
                                          logic [31:0] val, logic [5:0] dep,
                                          logic [5:0] row, logic [5:0] col,
                                          logic [4:0] sel);
    longint ms, dd, gx, gy, gz, gu, gv, pc, pr, c, r;
    int first, cnt;
    mask_res_t m;
    if (kind == KIND_GEO) begin
      if (idx < GEO_WORDS) geo_w[idx] = val;
      return 0;
    end
    if (kind == KIND_BOX) begin
      if (idx < BONES*4) box_w[idx] = val;
      return 0;
    end
    if (kind != KIND_VOX) return 0;
    ms = (map_r > MAX_MAP) ? MAX_MAP : map_r;
    dd = (dep_r > MAX_DEPTH) ? MAX_DEPTH : dep_r;
    gx = cube_pt(col, geo_w[4], geo_w[5], ms);
    gy = cube_pt(row, geo_w[6], geo_w[7], ms);
    gz = cube_pt(dep, geo_w[8], geo_w[9], dd);
    gu = sat32(div_sat(longint'(fx_r) * gx, gz) + longint'(cu_r));
    gv = sat32(div_sat(longint'(fy_r) * gy, gz) + longint'(cv_r));
    pc = pixel_of(gu, geo_w[0], geo_w[2]);
    pr = pixel_of(gv, geo_w[1], geo_w[3]);
    if (shared_r) begin
      first = 0;
      cnt = BONES;
    end else begin
      if (sel >= BONES) return 0;
      first = sel;
      cnt = 1;
    end
    c = pc <<< FRAC_BITS;
    r = pr <<< FRAC_BITS;
    for (int k = 0; k < cnt; k++) begin
      m.bone = 5'(first + k);
      m.dep = dep;
      m.row = row;
      m.col = col;
      m.in_patch = c >= box_w[(first+k)*4] && c < box_w[(first+k)*4+2] &&
                   r >= box_w[(first+k)*4+1] && r < box_w[(first+k)*4+3];
      m.value = m.in_patch ? val : 32'd0;
      m.last = (k + 1 == cnt);
      mask_q = {mask_q, m};
    end
    return cnt;
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // plausible load word: camera sees the cube, boxes are ordered
  function automatic logic [31:0] sane_word(logic [1:0] kind, logic [6:0] idx);
    logic [31:0] j;
    int half;
    j = $urandom_range(0, Q / 4);
    half = (img_r > 1) ? img_r / 2 : 1;
    if (kind == KIND_BOX) begin
      if (idx[1:0] < 2) return 32'($urandom_range(0, half)) << FRAC_BITS;
      return 32'($urandom_range(half, img_r + 1)) << FRAC_BITS;
    end
    case (idx)
      0, 1:    return -Q + j - Q / 8;
      2, 3:    return Q - j + Q / 8;
      4, 6:    return -Q - j;
      5, 7:    return Q + j;
      8:       return Q + j;
      default: return 3 * Q + j;
    endcase
  endfunction

  task automatic send_item(logic [1:0] kind, logic [6:0] idx, logic [31:0] val,
                           logic [5:0] dep, logic [5:0] row, logic [5:0] col,
                           logic [4:0] sel, int gap, output int n);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= kind;
    in_tdata <= {2'b00, sel, col, row, dep, val, idx};
    do @(posedge clk); while (!in_tready);
    n = project_and_mask(kind, idx, val, dep, row, col, sel);
    n_items++;
    if (kind == KIND_VOX) n_voxels++;
  endtask

  // leaves cfg_valid high; the caller drops it after the last write
  task automatic write_reg(logic [2:0] addr, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_addr <= addr;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (addr)
      REG_FOCAL_X:  fx_r = data;
      REG_FOCAL_Y:  fy_r = data;
      REG_CENTER_U: cu_r = data;
      REG_CENTER_V: cv_r = data;
      REG_IMG_SIZE: img_r = data[12:0];
      REG_MAP_SIZE: map_r = data[6:0];
      REG_DEPTH:    dep_r = data[6:0];
      default:      shared_r = data[0];
    endcase
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (mask_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_regs(logic [31:0] fx, logic [31:0] fy, logic [31:0] cu,
                          logic [31:0] cv, logic [31:0] img, logic [31:0] ms,
                          logic [31:0] dd, logic [31:0] sh);
    drain();
    write_reg(REG_FOCAL_X, fx);
    write_reg(REG_FOCAL_Y, fy);
    write_reg(REG_CENTER_U, cu);
    write_reg(REG_CENTER_V, cv);
    write_reg(REG_IMG_SIZE, img);
    write_reg(REG_MAP_SIZE, ms);
    write_reg(REG_DEPTH, dd);
    write_reg(REG_SHARED, sh);
    cfg_valid <= 1'b0;
  endtask

  task automatic add_row(logic [1:0] kind, logic [6:0] idx, logic [31:0] val,
                         logic [5:0] dep, logic [5:0] row, logic [5:0] col,
                         logic [4:0] sel, int n_res);
    dir_row_t d;
    d.kind = kind; d.idx = idx; d.val = val;
    d.dep = dep; d.row = row; d.col = col; d.sel = sel; d.n_res = n_res;
    dir_tab = {dir_tab, d};
  endtask

  task automatic random_items(int count, int pause_at);
    int r, n;
    logic [1:0] kind;
    logic [6:0] idx;
    logic [31:0] val;
    logic [5:0] dep, row, col;
    logic [4:0] sel;
    for (int i = 0; i < count; i++) begin
      if (i == pause_at) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
        while (mask_q.size() != 0) @(posedge clk);
      end
      r = $urandom_range(0, 99);
      val = $urandom;
      dep = $urandom; row = $urandom; col = $urandom; sel = $urandom;
      idx = $urandom;
      if (r < 65) begin
        kind = KIND_VOX;
        if ($urandom_range(0, 4) != 0) begin
          dep = $urandom_range(0, (dep_r > 0 ? dep_r : 1) - 1);
          row = $urandom_range(0, (map_r > 0 ? map_r : 1) - 1);
          col = $urandom_range(0, (map_r > 0 ? map_r : 1) - 1);
        end
        if ($urandom_range(0, 6) != 0) sel = $urandom_range(0, BONES - 1);
      end else if (r < 80) begin
        kind = KIND_GEO;
        idx = $urandom_range(0, GEO_WORDS - 1);
        val = sane_word(kind, idx);
      end else if (r < 92) begin
        kind = KIND_BOX;
        idx = $urandom_range(0, BONES*4 - 1);
        val = sane_word(kind, idx);
      end else if (r < 95) begin
        kind = $urandom_range(0, 1);
        idx = (kind == KIND_GEO) ? $urandom_range(0, GEO_WORDS - 1)
                                 : $urandom_range(0, BONES*4 - 1);
      end else if (r < 98) begin
        kind = $urandom_range(0, 1);
        idx = (kind == KIND_GEO) ? $urandom_range(GEO_WORDS, 127)
                                 : $urandom_range(BONES*4, 127);
      end else begin
        kind = 2'd3;
      end
      send_item(kind, idx, val, dep, row, col, sel, gap_len(), n);
    end
  endtask

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    int r;
    forever begin
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (800) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 60) begin
          out_tready <= 1'b1;
          repeat ($urandom_range(1, 20)) @(posedge clk);
        end else begin
          out_tready <= 1'b0;
          repeat (r < 95 ? $urandom_range(1, 3) : $urandom_range(20, 80)) @(posedge clk);
        end
      end
    end
  end

  always @(posedge clk) begin
    mask_res_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tdata[4:0], out_tdata[10:5], out_tdata[16:11], out_tdata[22:17],
             out_tdata[23], out_tdata[55:24], out_tlast};
      n_results++;
      if (mask_q.size() == 0) begin
        if (errors < 10) $display("unexpected item: %p", got);
        errors++;
      end else begin
        want = mask_q.pop_front();
        if (got !== want) begin
          if (errors < 10) $display("mismatch: expected %p got %p", want, got);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      idle_cnt <= 0;
    else
      idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= WD_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", WD_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    int n;
    fx_r = 0; fy_r = 0; cu_r = 0; cv_r = 0;
    img_r = 128; map_r = 32; dep_r = 32; shared_r = 1'b1;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // fill every stored word before any voxel reads it
    for (int i = 0; i < GEO_WORDS; i++)
      send_item(KIND_GEO, 7'(i), sane_word(KIND_GEO, 7'(i)), 0, 0, 0, 0, gap_len(), n);
    for (int i = 0; i < BONES*4; i++)
      send_item(KIND_BOX, 7'(i), sane_word(KIND_BOX, 7'(i)), 0, 0, 0, 0, gap_len(), n);

    // reset settings: shared mode, focal zero
    add_row(KIND_VOX, 0, 32'h7FFF_FFFF, 0, 0, 0, 0, BONES);
    add_row(KIND_VOX, 7'h7F, 32'h8000_0000, 63, 63, 63, 31, BONES);
    add_row(2'd3, 7'h55, 32'hFFFF_FFFF, 63, 0, 63, 0, 0);
    add_row(KIND_GEO, 10, 32'h1234_5678, 0, 0, 0, 0, 0);
    add_row(KIND_BOX, 80, 32'hFFFF_FFFF, 0, 0, 0, 0, 0);
    add_row(KIND_BOX, 127, 32'h0, 0, 0, 0, 0, 0);
    // zero depth span: divisors go to zero
    add_row(KIND_GEO, 8, 32'h0, 0, 0, 0, 0, 0);
    add_row(KIND_GEO, 9, 32'h0, 0, 0, 0, 0, 0);
    add_row(KIND_VOX, 0, 32'h0001_0000, 5, 7, 9, 0, BONES);
    add_row(KIND_GEO, 8, Q, 0, 0, 0, 0, 0);
    add_row(KIND_GEO, 9, 3 * Q, 0, 0, 0, 0, 0);
    // crop box collapsed
    add_row(KIND_GEO, 2, -Q, 0, 0, 0, 0, 0);
    add_row(KIND_GEO, 0, -Q, 0, 0, 0, 0, 0);
    add_row(KIND_VOX, 0, 32'hDEAD_BEEF, 1, 2, 3, 0, BONES);
    add_row(KIND_GEO, 2, Q, 0, 0, 0, 0, 0);
    // extreme cube bounds saturate the x coordinate
    add_row(KIND_GEO, 4, 32'h8000_0000, 0, 0, 0, 0, 0);
    add_row(KIND_GEO, 5, 32'h7FFF_FFFF, 0, 0, 0, 0, 0);
    add_row(KIND_VOX, 0, 32'h5555_AAAA, 63, 63, 63, 0, BONES);
    add_row(KIND_GEO, 4, -Q, 0, 0, 0, 0, 0);
    add_row(KIND_GEO, 5, Q, 0, 0, 0, 0, 0);
    // empty box for bone 0, then a voxel in the middle
    add_row(KIND_BOX, 2, 32'h0, 0, 0, 0, 0, 0);
    add_row(KIND_VOX, 0, 32'hAAAA_5555, 16, 16, 16, 0, BONES);
    foreach (dir_tab[i]) begin
      send_item(dir_tab[i].kind, dir_tab[i].idx, dir_tab[i].val, dir_tab[i].dep,
                dir_tab[i].row, dir_tab[i].col, dir_tab[i].sel, gap_len(), n);
      if (dir_tab[i].n_res >= 0 && n != dir_tab[i].n_res) begin
        if (errors < 10)
          $display("row %0d: %0d results predicted, %0d listed", i, n, dir_tab[i].n_res);
        errors++;
      end
    end

    // per-bone mode, out of range bones included
    set_regs(Q, Q, 0, 0, 128, 32, 32, 0);
    send_item(KIND_VOX, 0, 32'h0BAD_F00D, 3, 3, 3, 25, 0, n);
    send_item(KIND_VOX, 0, 32'h0BAD_F00D, 3, 3, 3, BONES - 1, 0, n);
    random_items(PER_PHASE, -1);

    set_regs(2 * Q, -Q, Q / 4, -Q / 4, 4096, 64, 64, 1);
    hold_req = 1'b1;
    random_items(PER_PHASE, -1);

    set_regs(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 1, 1, 1, 0);
    random_items(PER_PHASE, -1);

    set_regs(Q, Q, 0, 0, 64, 8, 16, 1);
    random_items(PER_PHASE, PER_PHASE / 2);

    set_regs($urandom_range(Q / 2, 4 * Q), $urandom_range(Q / 2, 4 * Q), $urandom, $urandom,
             $urandom_range(1, 4096), $urandom_range(1, 64), $urandom_range(1, 64), 0);
    random_items(PER_PHASE, -1);

    drain();
    $display("run: %0d items (%0d voxels), %0d results checked, 6 register settings",
             n_items, n_voxels, n_results);
    $display("covered shared and per-bone modes, zero divisors, saturation, stalls");
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches", errors);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- voxel_project_bone_patch_mask.f -----
rtl/core/vpbm_pkg.sv
rtl/core/vpbm_ram.sv
rtl/core/vpbm_div.sv
rtl/core/vpbm_dp.sv
rtl/core/vpbm_ctrl.sv
rtl/core/voxel_project_bone_patch_mask.sv
tb/tb_top.sv
